/* rtl/bfba_pkg.sv */
// Package: shared types, defaults and command codes for the best-fit block allocator.
`default_nettype none
package bfba_pkg;

  localparam int NUM_BLOCKS_DEF = 16;
  localparam int SIZE_BITS_DEF  = 16;

  localparam int IDX_BITS   = 4;
  localparam int AMT_BITS   = 16;
  localparam int TOTAL_BITS = 20;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_ALLOC = 1'b1;

  typedef struct packed {
    logic                cmd;
    logic [IDX_BITS-1:0] block_index;
    logic [AMT_BITS-1:0] amount;
  } req_t;

  typedef struct packed {
    logic                  granted;
    logic [IDX_BITS-1:0]   chosen_block;
    logic [AMT_BITS-1:0]   left_in_block;
    logic [TOTAL_BITS-1:0] total_free;
  } rsp_t;

endpackage
`default_nettype wire

/* rtl/best_fit_block_allocator.sv */
// Top level: best-fit allocator over a table of block free sizes held in a memory.
//
// Command channel: a word on req is taken at a clock edge with start high and
// busy low. cmd = load writes one block's free size; cmd = alloc searches all
// blocks for the smallest free size that still covers the amount (lowest index
// wins a tie), shrinks that block and grants it, or refuses.
// Result channel: done is high for exactly one cycle with the word on rsp;
// the receiver cannot stall, so no result is ever held back.
// A load reads the old size, then writes the new size and updates the total,
// then registers its result. An out-of-range load writes nothing and registers
// its result on acceptance. An alloc walks the table one entry per cycle
// through the memory's single read port, then passes S_SCAN_LAST and S_GRANT.
// One word is in flight at a time; busy is high until the result shows.
// Reset (synchronous, rst) clears the running total and the per-entry valid
// bits, so every block reads as free size zero; no clearing pass is needed.
`default_nettype none
module best_fit_block_allocator
  import bfba_pkg::*;
#(
  parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
  parameter int SIZE_BITS  = SIZE_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic      busy,
  input  wire req_t req,
  output logic      done,
  output rsp_t      rsp
);

  localparam int ADDR_BITS = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LD_RD,
    S_LD_WR,
    S_SCAN,
    S_SCAN_LAST,
    S_GRANT
  } state_t;

  state_t state;

  // size table and its valid bits
  logic [SIZE_BITS-1:0]  mem [NUM_BLOCKS];
  logic [NUM_BLOCKS-1:0] entry_vld;
  logic [ADDR_BITS-1:0]  raddr;
  logic [ADDR_BITS-1:0]  waddr;
  logic [SIZE_BITS-1:0]  wdata;
  logic                  we;
  logic [SIZE_BITS-1:0]  rd_data;
  logic                  rd_vld;
  logic [SIZE_BITS-1:0]  cur_size;

  // captured word and scan state
  logic [ADDR_BITS-1:0]  op_addr;
  logic [IDX_BITS-1:0]   op_idx;
  logic [SIZE_BITS-1:0]  op_amt;
  logic [ADDR_BITS-1:0]  scan_cnt;
  logic [ADDR_BITS-1:0]  cmp_idx;
  logic                  cmp_en;
  logic                  found;
  logic [SIZE_BITS-1:0]  best;
  logic [ADDR_BITS-1:0]  best_i;
  logic [TOTAL_BITS-1:0] free_total;
  logic [TOTAL_BITS-1:0] total_next;

  logic in_range;

  assign in_range = (32'(req.block_index) < NUM_BLOCKS);
  assign busy     = (state != S_IDLE);
  assign cur_size = rd_vld ? rd_data : '0;

  always_comb begin
    raddr = scan_cnt;
    we    = 1'b0;
    waddr = op_addr;
    wdata = op_amt;
    case (state)
      S_LD_RD: raddr = op_addr;
      S_LD_WR: we = 1'b1;
      S_GRANT: begin
        we    = found;
        waddr = best_i;
        wdata = best - op_amt;
      end
      default: ;
    endcase
  end

  always_comb begin
    total_next = free_total;
    case (state)
      S_LD_WR: total_next = free_total - TOTAL_BITS'(cur_size) + TOTAL_BITS'(op_amt);
      S_GRANT: if (found) total_next = free_total - TOTAL_BITS'(op_amt);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_data <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_vld <= '0;
      rd_vld    <= 1'b0;
    end else begin
      rd_vld <= entry_vld[raddr];
      if (we) entry_vld[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      done       <= 1'b0;
      free_total <= '0;
      cmp_en     <= 1'b0;
      found      <= 1'b0;
      scan_cnt   <= '0;
    end else begin
      done       <= 1'b0;
      free_total <= total_next;
      cmp_en     <= (state == S_SCAN);
      cmp_idx    <= scan_cnt;

      // best-fit compare on the word that just came out of the memory
      if (cmp_en && cur_size >= op_amt && (!found || cur_size < best)) begin
        found  <= 1'b1;
        best   <= cur_size;
        best_i <= cmp_idx;
      end

      case (state)
        S_IDLE: begin
          if (start) begin
            op_addr  <= ADDR_BITS'(req.block_index);
            op_idx   <= req.block_index;
            op_amt   <= SIZE_BITS'(req.amount);
            scan_cnt <= '0;
            found    <= 1'b0;
            if (req.cmd == CMD_ALLOC) begin
              state <= S_SCAN;
            end else if (in_range) begin
              state <= S_LD_RD;
            end else begin
              // nothing to write: report the index and the unchanged total
              done              <= 1'b1;
              rsp.granted       <= 1'b0;
              rsp.chosen_block  <= req.block_index;
              rsp.left_in_block <= '0;
              rsp.total_free    <= free_total;
            end
          end
        end
        S_LD_RD: state <= S_LD_WR;
        S_LD_WR: begin
          state             <= S_IDLE;
          done              <= 1'b1;
          rsp.granted       <= 1'b0;
          rsp.chosen_block  <= op_idx;
          rsp.left_in_block <= AMT_BITS'(op_amt);
          rsp.total_free    <= total_next;
        end
        S_SCAN: begin
          if (scan_cnt == ADDR_BITS'(NUM_BLOCKS - 1)) begin
            state <= S_SCAN_LAST;
          end else begin
            scan_cnt <= scan_cnt + ADDR_BITS'(1);
          end
        end
        S_SCAN_LAST: state <= S_GRANT;
        S_GRANT: begin
          state          <= S_IDLE;
          done           <= 1'b1;
          rsp.granted    <= found;
          rsp.total_free <= total_next;
          if (found) begin
            rsp.chosen_block  <= IDX_BITS'(best_i);
            rsp.left_in_block <= AMT_BITS'(best - op_amt);
          end else begin
            rsp.chosen_block  <= '0;
            rsp.left_in_block <= '0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
